>>> hw/rtl/spnh_pkg.sv
// shared types and constants of the shortest path next hop unit
package spnh_pkg;

	localparam int NODE_BITS     = 6;
	localparam int DIST_BITS     = 23;
	localparam int OUT_DIST_BITS = 22;
	localparam int IN_WEIGHT_BITS = 16;
	localparam int LINK_AW       = 12;
	localparam int LINK_DEPTH    = 4096;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 7;

	localparam logic [DIST_BITS-1:0] DIST_INF = 23'h400000;
	localparam logic [DIST_BITS-1:0] DIST_MAX = 23'h3FFFFF;

	localparam logic [CFG_IDX_BITS-1:0] REG_NODE_COUNT     = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_SOURCE_NODE    = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_SOURCE_PRESENT = 2'd2;

	// datapath operations, one per cycle
	typedef enum logic [3:0] {
		OP_CLEAR, OP_ACCEPT, OP_INIT, OP_IRD, OP_ILD, OP_JRD, OP_JCMP, OP_IWB,
		OP_CHECK, OP_RRD, OP_RUP, OP_ORD, OP_OLD, OP_CEVAL, OP_CLD, OP_EMIT
	} dp_op_t;

	// controller states
	typedef enum logic [3:0] {
		ST_CLEAR, ST_ACCEPT, ST_INIT, ST_IRD, ST_ILD, ST_JRD, ST_JCMP, ST_IWB,
		ST_CHECK, ST_RRD, ST_RUP, ST_ORD, ST_OLD, ST_CEVAL, ST_CLD, ST_EMIT
	} st_t;

	typedef struct packed {
		dp_op_t op;
	} cmd_t;

	typedef struct packed {
		logic item_last;
		logic clear_last;
		logic init_last;
		logic run_ok;
		logic j_end;
		logic j_last;
		logic i_last;
		logic u_inf;
		logic v_last;
		logic head_last;
		logic chain_go;
		logic step_go;
		logic out_free;
		logic k_last;
	} stat_t;

endpackage

>>> hw/rtl/shortest_path_next_hop_unit.sv
// edge items: one per cycle while in_stall is low, each written into the link store at once
// run after the last edge: an init pass over the n nodes, then a sort pass over each unsettled tail
//   and a relax pass over all n nodes per settled node
// results: one per node, with a walk up the parent chain for each node but the source, then a clear pass
// reset: config to 64 nodes, source 0, present; a clear pass of the link
//   store runs after reset and after every run, with in_stall high throughout
module shortest_path_next_hop_unit #(
	parameter int MAX_NODES   = 64,
	parameter int WEIGHT_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [spnh_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [spnh_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [spnh_pkg::NODE_BITS-1:0]      from_node,
	input  logic [spnh_pkg::NODE_BITS-1:0]      to_node,
	input  logic [spnh_pkg::IN_WEIGHT_BITS-1:0] weight,
	input  logic                                last,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [spnh_pkg::NODE_BITS-1:0]      node,
	output logic                                reachable,
	output logic [spnh_pkg::OUT_DIST_BITS-1:0]  distance,
	output logic                                has_parent,
	output logic [spnh_pkg::NODE_BITS-1:0]      parent,
	output logic                                has_next_hop,
	output logic [spnh_pkg::NODE_BITS-1:0]      first_hop,
	output logic                                end_of_run
);

	spnh_pkg::cmd_t  cmd;
	spnh_pkg::stat_t stat;

	spnh_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .stat(stat), .cmd(cmd)
	);

	spnh_dpath #(.MAX_NODES(MAX_NODES), .WEIGHT_BITS(WEIGHT_BITS)) u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .from_node(from_node), .to_node(to_node),
		.weight(weight), .last(last),
		.out_valid(out_valid), .out_stall(out_stall), .node(node),
		.reachable(reachable), .distance(distance), .has_parent(has_parent),
		.parent(parent), .has_next_hop(has_next_hop), .first_hop(first_hop),
		.end_of_run(end_of_run)
	);

	// edge items are taken only while waiting for edges
	assign in_stall = cmd.op != spnh_pkg::OP_ACCEPT;

	// the final edge starts a run, which closes the input
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && last) |=> in_stall)
		else $error("input open after final edge");

	// a next hop needs a parent and a finite distance
	a_hop_reach: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && has_next_hop) |-> (reachable && has_parent))
		else $error("next hop on unreachable node");

	// unreachable nodes carry no distance and no parent
	a_unreach: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !reachable) |-> ((distance == '0) && !has_parent))
		else $error("unreachable node with path data");

endmodule

>>> hw/rtl/spnh_ram.sv
// generic single write port ram with registered read
module spnh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hw/rtl/spnh_ctrl.sv
// sequencing state machine of the shortest path next hop unit
module spnh_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  spnh_pkg::stat_t stat,
	output spnh_pkg::cmd_t  cmd
);

	spnh_pkg::st_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spnh_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and command
	always_comb begin
		state_d = state_q;
		cmd.op  = spnh_pkg::OP_CLEAR;
		unique case (state_q)
			spnh_pkg::ST_CLEAR: begin
				cmd.op = spnh_pkg::OP_CLEAR;
				if (stat.clear_last) state_d = spnh_pkg::ST_ACCEPT;
			end
			spnh_pkg::ST_ACCEPT: begin
				cmd.op = spnh_pkg::OP_ACCEPT;
				if (stat.item_last) state_d = spnh_pkg::ST_INIT;
			end
			spnh_pkg::ST_INIT: begin
				cmd.op = spnh_pkg::OP_INIT;
				if (stat.init_last) begin
					state_d = stat.run_ok ? spnh_pkg::ST_IRD : spnh_pkg::ST_ORD;
				end
			end
			spnh_pkg::ST_IRD: begin
				cmd.op  = spnh_pkg::OP_IRD;
				state_d = spnh_pkg::ST_ILD;
			end
			spnh_pkg::ST_ILD: begin
				cmd.op  = spnh_pkg::OP_ILD;
				state_d = stat.j_end ? spnh_pkg::ST_IWB : spnh_pkg::ST_JRD;
			end
			spnh_pkg::ST_JRD: begin
				cmd.op  = spnh_pkg::OP_JRD;
				state_d = spnh_pkg::ST_JCMP;
			end
			spnh_pkg::ST_JCMP: begin
				cmd.op  = spnh_pkg::OP_JCMP;
				state_d = stat.j_last ? spnh_pkg::ST_IWB : spnh_pkg::ST_JRD;
			end
			spnh_pkg::ST_IWB: begin
				cmd.op  = spnh_pkg::OP_IWB;
				state_d = stat.i_last ? spnh_pkg::ST_CHECK : spnh_pkg::ST_IRD;
			end
			spnh_pkg::ST_CHECK: begin
				cmd.op  = spnh_pkg::OP_CHECK;
				state_d = stat.u_inf ? spnh_pkg::ST_ORD : spnh_pkg::ST_RRD;
			end
			spnh_pkg::ST_RRD: begin
				cmd.op  = spnh_pkg::OP_RRD;
				state_d = spnh_pkg::ST_RUP;
			end
			spnh_pkg::ST_RUP: begin
				cmd.op = spnh_pkg::OP_RUP;
				if (stat.v_last) begin
					state_d = stat.head_last ? spnh_pkg::ST_ORD : spnh_pkg::ST_IRD;
				end else begin
					state_d = spnh_pkg::ST_RRD;
				end
			end
			spnh_pkg::ST_ORD: begin
				cmd.op  = spnh_pkg::OP_ORD;
				state_d = spnh_pkg::ST_OLD;
			end
			spnh_pkg::ST_OLD: begin
				cmd.op  = spnh_pkg::OP_OLD;
				state_d = stat.chain_go ? spnh_pkg::ST_CEVAL : spnh_pkg::ST_EMIT;
			end
			spnh_pkg::ST_CEVAL: begin
				cmd.op  = spnh_pkg::OP_CEVAL;
				state_d = stat.step_go ? spnh_pkg::ST_CLD : spnh_pkg::ST_EMIT;
			end
			spnh_pkg::ST_CLD: begin
				cmd.op  = spnh_pkg::OP_CLD;
				state_d = spnh_pkg::ST_CEVAL;
			end
			spnh_pkg::ST_EMIT: begin
				cmd.op = spnh_pkg::OP_EMIT;
				if (stat.out_free) begin
					state_d = stat.k_last ? spnh_pkg::ST_CLEAR : spnh_pkg::ST_ORD;
				end
			end
			default: begin
				state_d = spnh_pkg::ST_CLEAR;
			end
		endcase
	end

endmodule

>>> hw/rtl/spnh_dpath.sv
// datapath: config registers, link store, queue, position store, distance store, result register
module spnh_dpath #(
	parameter int MAX_NODES   = 64,
	parameter int WEIGHT_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  spnh_pkg::cmd_t                        cmd,
	output spnh_pkg::stat_t                       stat,
	input  logic                                  cfg_we,
	input  logic [spnh_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [spnh_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	input  logic                                  in_valid,
	input  logic [spnh_pkg::NODE_BITS-1:0]        from_node,
	input  logic [spnh_pkg::NODE_BITS-1:0]        to_node,
	input  logic [spnh_pkg::IN_WEIGHT_BITS-1:0]   weight,
	input  logic                                  last,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [spnh_pkg::NODE_BITS-1:0]        node,
	output logic                                  reachable,
	output logic [spnh_pkg::OUT_DIST_BITS-1:0]    distance,
	output logic                                  has_parent,
	output logic [spnh_pkg::NODE_BITS-1:0]        parent,
	output logic                                  has_next_hop,
	output logic [spnh_pkg::NODE_BITS-1:0]        first_hop,
	output logic                                  end_of_run
);

	localparam int IW = $clog2(MAX_NODES);
	localparam int CW = $clog2(MAX_NODES + 1);
	localparam int DB = spnh_pkg::DIST_BITS;
	localparam int NB = spnh_pkg::NODE_BITS;
	localparam int QW = IW + DB;
	localparam int DW = DB + 1 + IW;
	localparam int SW = ((WEIGHT_BITS > DB) ? WEIGHT_BITS : DB) + 1;

	// config registers
	logic [6:0]    count_q;
	logic [NB-1:0] src_q;
	logic          present_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= 7'd64;
			src_q     <= '0;
			present_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				spnh_pkg::REG_NODE_COUNT:     count_q   <= cfg_data;
				spnh_pkg::REG_SOURCE_NODE:    src_q     <= cfg_data[NB-1:0];
				spnh_pkg::REG_SOURCE_PRESENT: present_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// saturated node count and run condition
	logic [6:0]    n7;
	logic [CW-1:0] n;
	logic          run_ok;

	always_comb begin
		if (count_q < 7'd2) begin
			n7 = 7'd2;
		end else if (count_q > 7'(MAX_NODES)) begin
			n7 = 7'(MAX_NODES);
		end else begin
			n7 = count_q;
		end
		n      = n7[CW-1:0];
		run_ok = present_q && ({1'b0, src_q} < n7);
	end

	// counters and working registers
	logic [spnh_pkg::LINK_AW-1:0] clr_q;
	logic [CW-1:0] k_q, i_q, j_q, v_q, head_q, steps_q;
	logic [IW-1:0] u_q, d_q, hop_q, cpar_q, cur_node_q;
	logic [DB-1:0] du_q, cur_dist_q;
	logic          cpv_q, hop_ok_q;
	logic          o_reach_q, o_pv_q;
	logic [spnh_pkg::OUT_DIST_BITS-1:0] o_dist_q;
	logic [NB-1:0] o_par_q;

	// memory ports
	logic                         link_we;
	logic [spnh_pkg::LINK_AW-1:0] link_waddr, link_raddr;
	logic [WEIGHT_BITS-1:0]       link_wdata, link_rdata;
	logic          q_we, pos_we, dm_we;
	logic [IW-1:0] q_waddr, q_raddr, pos_waddr, pos_raddr, dm_waddr, dm_raddr;
	logic [QW-1:0] q_wdata, q_rdata;
	logic [IW-1:0] pos_wdata, pos_rdata;
	logic [DW-1:0] dm_wdata, dm_rdata;

	spnh_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(spnh_pkg::LINK_DEPTH)) u_link (
		.clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
		.raddr(link_raddr), .rdata(link_rdata)
	);
	spnh_ram #(.WIDTH(QW), .DEPTH(MAX_NODES)) u_queue (
		.clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
		.raddr(q_raddr), .rdata(q_rdata)
	);
	spnh_ram #(.WIDTH(IW), .DEPTH(MAX_NODES)) u_pos (
		.clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
		.raddr(pos_raddr), .rdata(pos_rdata)
	);
	spnh_ram #(.WIDTH(DW), .DEPTH(MAX_NODES)) u_dist (
		.clk(clk), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
		.raddr(dm_raddr), .rdata(dm_rdata)
	);

	// derived values
	logic          in_xfer, out_free;
	logic [IW-1:0] k_idx, i_idx, j_idx, v_idx;
	logic [DB-1:0] init_dist, qd, dr, sat;
	logic [IW-1:0] qn;
	logic [SW-1:0] sum;
	logic          swap, relax, k_last;

	always_comb begin
		in_xfer   = (cmd.op == spnh_pkg::OP_ACCEPT) && in_valid;
		out_free  = !out_valid || !out_stall;
		k_idx     = k_q[IW-1:0];
		i_idx     = i_q[IW-1:0];
		j_idx     = j_q[IW-1:0];
		v_idx     = v_q[IW-1:0];
		init_dist = (run_ok && (NB'(k_idx) == src_q)) ? '0 : spnh_pkg::DIST_INF;
		qd        = q_rdata[DB-1:0];
		qn        = q_rdata[QW-1 -: IW];
		dr        = dm_rdata[DW-1 -: DB];
		swap      = qd < cur_dist_q;
		sum       = SW'(du_q) + SW'(link_rdata);
		sat       = (sum > SW'(spnh_pkg::DIST_MAX)) ? spnh_pkg::DIST_MAX : sum[DB-1:0];
		relax     = (link_rdata != '0) && (CW'(pos_rdata) > head_q) && (sat < dr);
		k_last    = (k_q + CW'(1)) >= n;
	end

	// status to the controller
	always_comb begin
		stat.item_last  = in_xfer && last;
		stat.clear_last = clr_q == spnh_pkg::LINK_AW'(spnh_pkg::LINK_DEPTH - 1);
		stat.init_last  = k_last;
		stat.run_ok     = run_ok;
		stat.j_end      = (i_q + CW'(1)) >= n;
		stat.j_last     = (j_q + CW'(1)) >= n;
		stat.i_last     = (i_q + CW'(1)) >= n;
		stat.u_inf      = du_q == spnh_pkg::DIST_INF;
		stat.v_last     = (v_q + CW'(1)) >= n;
		stat.head_last  = (head_q + CW'(1)) >= n;
		stat.chain_go   = run_ok && (NB'(k_idx) != src_q);
		stat.step_go    = cpv_q && (steps_q < CW'(MAX_NODES));
		stat.out_free   = out_free;
		stat.k_last     = k_last;
	end

	// memory address and write selection
	always_comb begin
		link_we    = 1'b0;
		link_waddr = {from_node, to_node};
		link_wdata = WEIGHT_BITS'(weight);
		link_raddr = {NB'(u_q), NB'(v_idx)};
		q_we       = 1'b0;
		q_waddr    = k_idx;
		q_wdata    = {k_idx, init_dist};
		q_raddr    = i_idx;
		pos_we     = 1'b0;
		pos_waddr  = k_idx;
		pos_wdata  = k_idx;
		pos_raddr  = v_idx;
		dm_we      = 1'b0;
		dm_waddr   = k_idx;
		dm_wdata   = {init_dist, 1'b0, {IW{1'b0}}};
		dm_raddr   = v_idx;
		case (cmd.op)
			spnh_pkg::OP_CLEAR: begin
				link_we    = 1'b1;
				link_waddr = clr_q;
				link_wdata = '0;
			end
			spnh_pkg::OP_ACCEPT: begin
				link_we = in_xfer;
			end
			spnh_pkg::OP_INIT: begin
				q_we   = 1'b1;
				pos_we = 1'b1;
				dm_we  = 1'b1;
			end
			spnh_pkg::OP_JRD: begin
				q_raddr = j_idx;
			end
			spnh_pkg::OP_JCMP: begin
				q_we      = swap;
				q_waddr   = j_idx;
				q_wdata   = {cur_node_q, cur_dist_q};
				pos_we    = swap;
				pos_waddr = cur_node_q;
				pos_wdata = j_idx;
			end
			spnh_pkg::OP_IWB: begin
				q_we      = 1'b1;
				q_waddr   = i_idx;
				q_wdata   = {cur_node_q, cur_dist_q};
				pos_we    = 1'b1;
				pos_waddr = cur_node_q;
				pos_wdata = i_idx;
			end
			spnh_pkg::OP_RUP: begin
				dm_we    = relax;
				dm_waddr = v_idx;
				dm_wdata = {sat, 1'b1, u_q};
				q_we     = relax;
				q_waddr  = pos_rdata;
				q_wdata  = {v_idx, sat};
			end
			spnh_pkg::OP_ORD: begin
				dm_raddr = k_idx;
			end
			spnh_pkg::OP_CEVAL: begin
				dm_raddr = cpar_q;
			end
			default: ;
		endcase
	end

	// clear counter and output valid, with reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.op == spnh_pkg::OP_CLEAR) begin
				clr_q <= clr_q + spnh_pkg::LINK_AW'(1);
			end
			if ((cmd.op == spnh_pkg::OP_EMIT) && out_free) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// run registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			spnh_pkg::OP_ACCEPT: begin
				k_q <= '0;
			end
			spnh_pkg::OP_INIT: begin
				if (k_last) begin
					k_q    <= '0;
					head_q <= '0;
					i_q    <= '0;
				end else begin
					k_q <= k_q + CW'(1);
				end
			end
			spnh_pkg::OP_ILD: begin
				cur_node_q <= qn;
				cur_dist_q <= qd;
				j_q        <= i_q + CW'(1);
			end
			spnh_pkg::OP_JCMP: begin
				if (swap) begin
					cur_node_q <= qn;
					cur_dist_q <= qd;
				end
				j_q <= j_q + CW'(1);
			end
			spnh_pkg::OP_IWB: begin
				if (i_q == head_q) begin
					u_q  <= cur_node_q;
					du_q <= cur_dist_q;
				end
				i_q <= i_q + CW'(1);
			end
			spnh_pkg::OP_CHECK: begin
				v_q <= '0;
			end
			spnh_pkg::OP_RUP: begin
				v_q <= v_q + CW'(1);
				if (stat.v_last) begin
					head_q <= head_q + CW'(1);
					i_q    <= head_q + CW'(1);
				end
			end
			spnh_pkg::OP_OLD: begin
				o_reach_q <= dr != spnh_pkg::DIST_INF;
				o_dist_q  <= (dr != spnh_pkg::DIST_INF) ? dr[spnh_pkg::OUT_DIST_BITS-1:0] : '0;
				o_pv_q    <= dm_rdata[IW];
				o_par_q   <= dm_rdata[IW] ? NB'(dm_rdata[IW-1:0]) : '0;
				cpv_q     <= dm_rdata[IW];
				cpar_q    <= dm_rdata[IW-1:0];
				d_q       <= k_idx;
				steps_q   <= '0;
				hop_q     <= '0;
				hop_ok_q  <= 1'b0;
			end
			spnh_pkg::OP_CEVAL: begin
				if (stat.step_go) begin
					hop_q   <= d_q;
					d_q     <= cpar_q;
					steps_q <= steps_q + CW'(1);
				end else begin
					hop_ok_q <= (NB'(d_q) == src_q) && !cpv_q && (steps_q != '0);
				end
			end
			spnh_pkg::OP_CLD: begin
				cpv_q  <= dm_rdata[IW];
				cpar_q <= dm_rdata[IW-1:0];
			end
			spnh_pkg::OP_EMIT: begin
				if (out_free) begin
					k_q          <= k_q + CW'(1);
					node         <= NB'(k_idx);
					reachable    <= o_reach_q;
					distance     <= o_dist_q;
					has_parent   <= o_pv_q;
					parent       <= o_par_q;
					has_next_hop <= hop_ok_q;
					first_hop    <= hop_ok_q ? NB'(hop_q) : '0;
					end_of_run   <= k_last;
				end
			end
			default: ;
		endcase
	end

endmodule

>>> verif/spnh_checker.sv
// route checker: mirrors the link store, predicts per-node routes and compares them
module spnh_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [spnh_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [spnh_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic [spnh_pkg::NODE_BITS-1:0]      from_node,
	input  logic [spnh_pkg::NODE_BITS-1:0]      to_node,
	input  logic [spnh_pkg::IN_WEIGHT_BITS-1:0] weight,
	input  logic                                last,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic [spnh_pkg::NODE_BITS-1:0]      node,
	input  logic                                reachable,
	input  logic [spnh_pkg::OUT_DIST_BITS-1:0]  distance,
	input  logic                                has_parent,
	input  logic [spnh_pkg::NODE_BITS-1:0]      parent,
	input  logic                                has_next_hop,
	input  logic [spnh_pkg::NODE_BITS-1:0]      first_hop,
	input  logic                                end_of_run,
	output int                                  errors,
	output int                                  pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [spnh_pkg::NODE_BITS-1:0]     node;
		logic                               reachable;
		logic [spnh_pkg::OUT_DIST_BITS-1:0] distance;
		logic                               has_parent;
		logic [spnh_pkg::NODE_BITS-1:0]     parent;
		logic                               has_next_hop;
		logic [spnh_pkg::NODE_BITS-1:0]     first_hop;
		logic                               end_of_run;
	} route_t;

	logic [spnh_pkg::IN_WEIGHT_BITS-1:0] link_wt [spnh_pkg::LINK_DEPTH];
	logic [6:0]                          cur_count;
	logic [spnh_pkg::NODE_BITS-1:0]      cur_source;
	logic                                cur_present;
	route_t                              route_q [$];

	assign pending = route_q.size();

	// run the search over the mirrored store and queue one route per node
	task automatic predict_routes();
		logic [spnh_pkg::DIST_BITS-1:0] cost [64];
		logic [spnh_pkg::NODE_BITS-1:0] pred [64];
		logic                           pred_ok [64];
		logic [spnh_pkg::NODE_BITS-1:0] order [64];
		logic [spnh_pkg::NODE_BITS-1:0] tmp;
		logic [spnh_pkg::NODE_BITS-1:0] hop;
		logic [23:0]                    sum;
		logic                           run_ok;
		logic                           queued;
		logic                           hop_ok;
		int n, src, head, u, d, steps;
		route_t r;
		n = cur_count < 2 ? 2 : (cur_count > 64 ? 64 : int'(cur_count));
		src = cur_source;
		run_ok = cur_present && (src < n);
		for (int k = 0; k < n; k++) begin
			pred_ok[k] = 1'b0;
			pred[k] = '0;
			cost[k] = spnh_pkg::DIST_INF;
			order[k] = k[spnh_pkg::NODE_BITS-1:0];
		end
		head = 0;
		if (run_ok) begin
			cost[src] = '0;
			head = -1;
			while (head < n) begin
				// exchange sort of the unsettled tail, ties keep this exact order
				for (int i = (head < 0 ? 0 : head); i < n; i++)
					for (int j = i + 1; j < n; j++)
						if (cost[order[j]] < cost[order[i]]) begin
							tmp = order[j];
							order[j] = order[i];
							order[i] = tmp;
						end
				if (head < 0)
					head = 0;
				if (head >= n)
					break;
				u = order[head];
				if (cost[u] == spnh_pkg::DIST_INF)
					break;
				// relax into nodes still queued behind the head
				for (int v = 0; v < n; v++) begin
					queued = 1'b0;
					for (int i = head + 1; i < n; i++)
						if (order[i] == v)
							queued = 1'b1;
					if (link_wt[u*64+v] != 0 && queued) begin
						sum = cost[u] + link_wt[u*64+v];
						if (sum > spnh_pkg::DIST_MAX)
							sum = spnh_pkg::DIST_MAX;
						if (sum < cost[v]) begin
							cost[v] = sum[spnh_pkg::DIST_BITS-1:0];
							pred[v] = u[spnh_pkg::NODE_BITS-1:0];
							pred_ok[v] = 1'b1;
						end
					end
				end
				head++;
			end
		end
		for (int k = 0; k < n; k++) begin
			hop = '0;
			hop_ok = 1'b0;
			if (run_ok && k != src) begin
				d = k;
				steps = 0;
				while (pred_ok[d] && steps < 64) begin
					hop = d[spnh_pkg::NODE_BITS-1:0];
					d = pred[d];
					steps++;
				end
				hop_ok = (d == src) && !pred_ok[d] && steps > 0;
				if (!hop_ok)
					hop = '0;
			end
			r.node = k[spnh_pkg::NODE_BITS-1:0];
			r.reachable = cost[k] != spnh_pkg::DIST_INF;
			r.distance = r.reachable ? cost[k][spnh_pkg::OUT_DIST_BITS-1:0] : '0;
			r.has_parent = pred_ok[k];
			r.parent = pred_ok[k] ? pred[k] : '0;
			r.has_next_hop = hop_ok;
			r.first_hop = hop;
			r.end_of_run = (k + 1 == n);
			route_q.push_back(r);
		end
		for (int i = 0; i < spnh_pkg::LINK_DEPTH; i++)
			link_wt[i] = '0;
	endtask

	// mirror register writes and edge transfers
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_count = 7'd64;
			cur_source = '0;
			cur_present = 1'b1;
			for (int i = 0; i < spnh_pkg::LINK_DEPTH; i++)
				link_wt[i] = '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					spnh_pkg::REG_NODE_COUNT:     cur_count = cfg_data;
					spnh_pkg::REG_SOURCE_NODE:    cur_source = cfg_data[spnh_pkg::NODE_BITS-1:0];
					spnh_pkg::REG_SOURCE_PRESENT: cur_present = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				link_wt[{from_node, to_node}] = weight;
				if (last)
					predict_routes();
			end
		end
	end

	// compare each result transfer with the oldest predicted route
	always @(posedge clk or negedge arst_n) begin
		route_t got, want;
		if (!arst_n) begin
			errors = 0;
		end else if (out_valid && !out_stall) begin
			got = '{node, reachable, distance, has_parent, parent, has_next_hop, first_hop,
				end_of_run};
			if (route_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected route result %p", got);
			end else begin
				want = route_q.pop_front();
				if (got != want) begin
					errors++;
					if (errors <= 10)
						$display("route mismatch: expected %p, actual %p", want, got);
				end
			end
		end
	end

endmodule

>>> verif/tb_top.sv
// top of the route unit testbench: clock, reset, edge and register stimulus, verdict
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLEAR_WAIT = 5000;
	localparam int HOLD_CYCLES = 3000;
	localparam longint LIMIT = 4000000;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                cfg_we = 1'b0;
	logic [spnh_pkg::CFG_IDX_BITS-1:0]   cfg_index = '0;
	logic [spnh_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;
	logic                                in_valid = 1'b0;
	logic                                in_stall;
	logic [spnh_pkg::NODE_BITS-1:0]      from_node = '0;
	logic [spnh_pkg::NODE_BITS-1:0]      to_node = '0;
	logic [spnh_pkg::IN_WEIGHT_BITS-1:0] weight = '0;
	logic                                last = 1'b0;
	logic                                out_valid;
	logic                                out_stall = 1'b0;
	logic [spnh_pkg::NODE_BITS-1:0]      node;
	logic                                reachable;
	logic [spnh_pkg::OUT_DIST_BITS-1:0]  distance;
	logic                                has_parent;
	logic [spnh_pkg::NODE_BITS-1:0]      parent;
	logic                                has_next_hop;
	logic [spnh_pkg::NODE_BITS-1:0]      first_hop;
	logic                                end_of_run;
	int                                  errors;
	int                                  pending;
	int                                  edges_sent = 0;
	logic                                hold_req = 1'b0;
	logic                                hold_on = 1'b0;
	longint                              cycles = 0;

	shortest_path_next_hop_unit i_dut (.*);

	spnh_checker i_checker (.*);

	always #1 clk = ~clk;

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// one long receiver hold-off, counted here
	initial begin
		wait (hold_req);
		hold_on <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_on <= 1'b0;
	end

	// receiver stall pattern
	initial begin
		int mode;
		bit pat;
		forever begin
			mode = $urandom_range(0, 2);
			repeat ($urandom_range(16, 80)) begin
				case (mode)
					0: pat = 1'b0;
					1: pat = ($urandom_range(0, 9) < 3);
					default: pat = ($urandom_range(0, 9) < 8);
				endcase
				out_stall <= hold_on || pat;
				@(posedge clk);
			end
		end
	end

	task automatic write_reg(logic [spnh_pkg::CFG_IDX_BITS-1:0] idx, int val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[spnh_pkg::CFG_DATA_BITS-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// wait for every route and the clearing pass, then set up the next graph
	task automatic setup_graph(int count, int src, int present);
		while (pending != 0)
			@(posedge clk);
		repeat (CLEAR_WAIT) @(posedge clk);
		write_reg(spnh_pkg::REG_NODE_COUNT, count);
		write_reg(spnh_pkg::REG_SOURCE_NODE, src);
		write_reg(spnh_pkg::REG_SOURCE_PRESENT, present);
	endtask

	// one edge transfer, then an optional random gap
	task automatic send_edge(int f, int t, int w, bit fin, bit bursty);
		in_valid <= 1'b1;
		from_node <= f[spnh_pkg::NODE_BITS-1:0];
		to_node <= t[spnh_pkg::NODE_BITS-1:0];
		weight <= w[spnh_pkg::IN_WEIGHT_BITS-1:0];
		last <= fin;
		do @(posedge clk); while (in_stall);
		edges_sent++;
		if (fin || (bursty && $urandom_range(0, 3) == 0)) begin
			in_valid <= 1'b0;
			repeat (fin ? 1 : $urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	initial begin
		int nc, src, ne, f, t, w;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// two nodes, full weight, zero weight and an edge beyond the count
		setup_graph(2, 0, 1);
		send_edge(63, 63, 65535, 0, 0);
		send_edge(1, 0, 0, 0, 0);
		send_edge(0, 1, 65535, 1, 0);
		// count below range saturates to two
		setup_graph(0, 1, 1);
		send_edge(1, 0, 1, 1, 0);
		// count of one, absent source
		setup_graph(1, 0, 0);
		send_edge(0, 1, 7, 1, 0);
		// source outside the node count
		setup_graph(5, 7, 1);
		send_edge(0, 1, 3, 0, 0);
		send_edge(1, 2, 3, 1, 0);
		// ties between equal distances, rewritten entry, unreachable node
		setup_graph(6, 0, 1);
		send_edge(0, 1, 9, 0, 0);
		send_edge(0, 1, 2, 0, 0);
		send_edge(0, 2, 1, 0, 0);
		send_edge(2, 1, 1, 0, 0);
		send_edge(1, 3, 3, 0, 0);
		send_edge(2, 3, 3, 0, 0);
		send_edge(3, 4, 1, 0, 0);
		send_edge(4, 0, 1, 1, 0);
		// count above range, long chain of heavy links from the top source
		setup_graph(127, 63, 1);
		for (int i = 63; i > 1; i--)
			send_edge(i, i - 1, 65535, 0, 1);
		send_edge(1, 0, 65534, 1, 0);
		// full count, sparse random links
		setup_graph(64, 0, 1);
		for (int i = 0; i < 12; i++)
			send_edge($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(1, 65535),
				i == 11, 1);

		// random graphs, mostly small and well formed; the third one keeps the
		// second one's registers and is offered while the held results block the unit
		for (int g = 0; g < 3 || edges_sent < 100; g++) begin
			if (g != 2) begin
				nc = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 20) : $urandom_range(2, 12);
				src = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, nc - 1);
				setup_graph(nc, src, $urandom_range(0, 9) != 0);
			end
			if (g == 1)
				hold_req = 1'b1;
			ne = $urandom_range(1, 2 * nc);
			for (int i = 0; i < ne; i++) begin
				if ($urandom_range(0, 6) == 0) begin
					f = $urandom_range(0, 63);
					t = $urandom_range(0, 63);
				end else begin
					f = $urandom_range(0, nc - 1);
					t = $urandom_range(0, nc - 1);
				end
				case ($urandom_range(0, 9))
					0:       w = 0;
					1, 2, 3: w = $urandom_range(0, 65535);
					default: w = $urandom_range(1, 4);
				endcase
				send_edge(f, t, w, i == ne - 1, 1);
			end
		end

		while (pending != 0)
			@(posedge clk);
		repeat (CLEAR_WAIT) @(posedge clk);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
